// File: rtl/msstk_pkg.sv
`timescale 1ns / 1ps
// shared types for the monotonic sunset stack
// no dependencies

package msstk_pkg;

  localparam int unsigned FieldW = 16;

  typedef struct packed {
    logic [FieldW-1:0] height;
    logic [FieldW-1:0] position;
  } entry_t;

  typedef struct packed {
    entry_t ent;
    logic   last;
    logic   dropped;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_PUSH,
    ST_EMIT
  } state_e;

endpackage

// File: rtl/msstk_mem.sv
`timescale 1ns / 1ps
// stack entry storage: one write port, one registered read port
// uses msstk_pkg::entry_t

module msstk_mem #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned AW = 5
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  msstk_pkg::entry_t     wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output msstk_pkg::entry_t     rdata_o
);

  msstk_pkg::entry_t mem [STACK_DEPTH];
  msstk_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/msstk_outreg.sv
`timescale 1ns / 1ps
// output register holding one result until it is taken
// uses msstk_pkg::result_t

module msstk_outreg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  msstk_pkg::result_t  res_i,
  output logic                free_o,
  output logic                valid_o,
  input  logic                ready_i,
  output msstk_pkg::result_t  res_o
);

  logic               valid_q;
  msstk_pkg::result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: rtl/msstk_seq.sv
`timescale 1ns / 1ps
// sequencer: pops, pushes and walks the stack memory for one request
// uses msstk_pkg types; drives msstk_mem and msstk_outreg

module msstk_seq #(
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned AW = 5,
  parameter int unsigned CW = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [msstk_pkg::FieldW-1:0]    height_i,
  input  logic [msstk_pkg::FieldW-1:0]    position_i,
  output logic                            we_o,
  output logic [AW-1:0]                   waddr_o,
  output msstk_pkg::entry_t               wdata_o,
  output logic                            re_o,
  output logic [AW-1:0]                   raddr_o,
  input  msstk_pkg::entry_t               rdata_i,
  input  logic                            out_free_i,
  output logic                            load_o,
  output msstk_pkg::result_t              res_o
);

  msstk_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] k_q, k_d;
  logic          pend_q, pend_d;
  logic          drop_q, drop_d;
  msstk_pkg::entry_t req_q, req_d;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;

  assign cnt_m1 = cnt_q - CW'(1);
  assign cnt_m2 = cnt_q - CW'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msstk_pkg::ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      pend_q  <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
      drop_q  <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    pend_d     = pend_q;
    drop_d     = drop_q;
    req_d      = req_q;
    in_ready_o = 1'b0;
    we_o       = 1'b0;
    waddr_o    = cnt_q[AW-1:0];
    wdata_o    = req_q;
    re_o       = 1'b0;
    raddr_o    = cnt_m1[AW-1:0];
    load_o     = 1'b0;
    res_o.ent     = rdata_i;
    res_o.last    = (k_q == cnt_q);
    res_o.dropped = drop_q;

    case (state_q)
      msstk_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d.height   = height_i;
          req_d.position = position_i;
          if (cnt_q == '0) begin
            state_d = msstk_pkg::ST_PUSH;
          end else begin
            re_o    = 1'b1;
            raddr_o = cnt_m1[AW-1:0];
            state_d = msstk_pkg::ST_POP;
          end
        end
      end

      msstk_pkg::ST_POP: begin
        // read data is the current top entry
        if (rdata_i.height <= req_q.height) begin
          cnt_d = cnt_m1;
          if (cnt_m1 != '0) begin
            re_o    = 1'b1;
            raddr_o = cnt_m2[AW-1:0];
          end else begin
            state_d = msstk_pkg::ST_PUSH;
          end
        end else begin
          state_d = msstk_pkg::ST_PUSH;
        end
      end

      msstk_pkg::ST_PUSH: begin
        if (cnt_q < CW'(STACK_DEPTH)) begin
          we_o   = 1'b1;
          cnt_d  = cnt_q + CW'(1);
          drop_d = 1'b0;
        end else begin
          drop_d = 1'b1;
        end
        k_d     = '0;
        pend_d  = 1'b0;
        state_d = msstk_pkg::ST_EMIT;
      end

      msstk_pkg::ST_EMIT: begin
        load_o = pend_q && out_free_i;
        // read the next entry when the read register is free or draining
        if ((k_q != cnt_q) && (!pend_q || load_o)) begin
          re_o    = 1'b1;
          raddr_o = k_q[AW-1:0];
          k_d     = k_q + CW'(1);
          pend_d  = 1'b1;
        end else if (load_o) begin
          pend_d = 1'b0;
        end
        if (load_o && (k_q == cnt_q)) begin
          state_d = msstk_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = msstk_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/monotonic_sunset_stack.sv
`timescale 1ns / 1ps
// Keeps a strictly decreasing stack of (height, position) entries in a single
// port-pair memory. A request pops every stored entry whose height is at most
// the new height, pushes the new entry (or flags push_dropped when the stack is
// full and nothing popped), then streams the whole stack bottom to top with
// last_entry on the newest entry. Popping and streaming are paced by the
// one-entry-per-cycle read port of the stack memory; output backpressure
// stalls the stream. A new request is taken only once the previous run is
// fully handed to the output register. Memory contents need no clearing
// after reset.
// Depends on msstk_pkg, msstk_mem, msstk_seq and msstk_outreg.

module monotonic_sunset_stack #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] height_i,
  input  logic [15:0] position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] entry_height_o,
  output logic [15:0] entry_position_o,
  output logic        last_entry_o,
  output logic        push_dropped_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic               we;
  logic [AW-1:0]      waddr;
  msstk_pkg::entry_t  wdata;
  logic               re;
  logic [AW-1:0]      raddr;
  msstk_pkg::entry_t  rdata;
  logic               out_free;
  logic               load;
  msstk_pkg::result_t res_in;
  msstk_pkg::result_t res_out;

  msstk_mem #(
    .STACK_DEPTH(STACK_DEPTH),
    .AW         (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  msstk_seq #(
    .STACK_DEPTH(STACK_DEPTH),
    .AW         (AW),
    .CW         (CW)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .height_i  (height_i),
    .position_i(position_i),
    .we_o      (we),
    .waddr_o   (waddr),
    .wdata_o   (wdata),
    .re_o      (re),
    .raddr_o   (raddr),
    .rdata_i   (rdata),
    .out_free_i(out_free),
    .load_o    (load),
    .res_o     (res_in)
  );

  msstk_outreg u_outreg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .res_i  (res_in),
    .free_o (out_free),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .res_o  (res_out)
  );

  assign entry_height_o   = res_out.ent.height;
  assign entry_position_o = res_out.ent.position;
  assign last_entry_o     = res_out.last;
  assign push_dropped_o   = res_out.dropped;

  // a taken request always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready stayed high after a request");

  // results are produced only while a request is in progress
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !in_ready_o)
    else $error("result loaded while idle");

  // the output register is never overwritten while it holds an untaken result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_o || out_ready_i))
    else $error("pending result overwritten");

endmodule
